// ----- design/bpat_pkg.sv -----
// Shared constants and tables for the body pose axis-angle transform.
`default_nettype none
package bpat_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BODY_LIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN  = 2'd1;

    localparam logic signed [15:0] BODY_LIFT_RST = 16'sd0;
    localparam logic [13:0]        MAX_TURN_RST  = 14'd960;

    // CORDIC start value: gain-compensated unit in Q30
    localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

    // atan(2^-i) in units of 2^-16 degree
    function automatic logic signed [24:0] atan_deg16(input int i);
        logic signed [24:0] a;
        begin
            unique case (i)
                0:       a = 25'sd2949120;
                1:       a = 25'sd1740967;
                2:       a = 25'sd919879;
                3:       a = 25'sd466945;
                4:       a = 25'sd234379;
                5:       a = 25'sd117304;
                6:       a = 25'sd58666;
                7:       a = 25'sd29335;
                8:       a = 25'sd14668;
                9:       a = 25'sd7334;
                10:      a = 25'sd3667;
                11:      a = 25'sd1833;
                12:      a = 25'sd917;
                13:      a = 25'sd458;
                14:      a = 25'sd229;
                15:      a = 25'sd115;
                default: a = 25'sd0;
            endcase
            return a;
        end
    endfunction

endpackage
`default_nettype wire

// ----- design/bpat_if.sv -----
// Handshake channel interfaces: point input, transformed output, register writes.
`default_nettype none
interface bpat_in_if #(
    parameter int COORD_WIDTH = bpat_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] leg_x;
    logic signed [COORD_WIDTH-1:0] leg_y;
    logic signed [15:0]            move_x;
    logic signed [15:0]            move_y;
    logic signed [15:0]            move_z;
    logic signed [14:0]            rot_x;
    logic signed [14:0]            rot_y;
    logic signed [14:0]            rot_z;

    modport source (output valid, leg_x, leg_y, move_x, move_y, move_z, rot_x, rot_y, rot_z,
                    input ready);
    modport sink   (input valid, leg_x, leg_y, move_x, move_y, move_z, rot_x, rot_y, rot_z,
                    output ready);
endinterface

interface bpat_out_if #(
    parameter int COORD_WIDTH = bpat_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          saturated;

    modport source (output valid, out_x, out_y, out_z, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

interface bpat_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bpat_pkg::CFG_IDX_W-1:0]    idx;
    logic [bpat_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface
`default_nettype wire

// ----- design/body_pose_axis_angle_transform_core.sv -----
// Top level: pipelined shift and axis-angle rotation of one foot point.
//
// Usage:
//   in_ch  - one foot point per item: leg_x/leg_y, body shift move_x/y/z and
//            rotation vector rot_x/y/z (length = angle in 1/64 degree).
//   out_ch - one result item per input item, in order: out_x/y/z in 1/16 mm,
//            saturated when any coordinate was clipped.
//   cfg    - register writes (index 0 body_lift, 1 max_turn_angle); always
//            ready; other indexes are dropped. Write only while idle.
// Throughput: one item per cycle while out_ch is ready or the last stage is empty.
//   The depth is set by the vector length root (16 stages, 2 root bits each)
//   and the three axis dividers (20 stages, 1 quotient bit each; the 16 CORDIC
//   steps for sin/cos run beside the first 16 of them), plus 7 matrix stages.
// Stall: the whole pipe advances together when the last stage is empty or
//   out_ch is ready; in_ch.ready follows the same enable, so a held result
//   freezes every stage and nothing is dropped or repeated.
// Reset: rst_n clears all valid bits and loads body_lift = 0 and
//   max_turn_angle = 960; no clearing pass is needed.
`default_nettype none
module body_pose_axis_angle_transform_core #(
    parameter int COORD_WIDTH = bpat_pkg::COORD_WIDTH_DEF
) (
    input  wire      clk,
    input  wire      rst_n,
    bpat_in_if.sink  in_ch,
    bpat_out_if.source out_ch,
    bpat_cfg_if.sink cfg
);

    localparam int CW  = COORD_WIDTH;
    localparam int PW  = (CW + 1 > 17) ? CW + 1 : 17;   // shifted point width
    localparam int MW  = 30;                            // matrix entry, Q24
    localparam int PRW = MW + PW;
    localparam int AW  = PRW + 2;

    // stage map
    localparam int ST_SUM  = 1;
    localparam int ST_SQ   = 2;
    localparam int SQ_N    = 16;
    localparam int ST_PREP = ST_SQ + SQ_N;
    localparam int ST_DIV  = ST_PREP + 1;
    localparam int DIV_N   = 20;
    localparam int CORD_N  = 16;
    localparam int ST_F1   = ST_DIV + DIV_N;
    localparam int NST     = ST_F1 + 7;
    localparam int LAST    = NST - 1;

    localparam logic signed [AW-1:0] OHI = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [AW-1:0] OLO = {{(AW-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam logic signed [AW-1:0] RND = {{(AW-24){1'b0}}, 1'b1, 23'b0};

    typedef struct {
        logic signed [PW-1:0]  p [3];
        logic signed [14:0]    r [3];
        logic [29:0]           sq [3];
        logic [31:0]           s;
        logic                  zero;
        logic [33:0]           srem;
        logic [31:0]           lh;       // sqrt root, then floor(|r| * 2^16)
        logic                  flip;
        logic signed [31:0]    cx;
        logic signed [31:0]    cy;
        logic signed [24:0]    cz;
        logic [51:0]           drem [3];
        logic [19:0]           dq [3];
        logic                  neg [3];
        logic signed [25:0]    c;
        logic signed [25:0]    sn;
        logic signed [26:0]    v;
        logic signed [19:0]    k [3];
        logic signed [39:0]    kk [6];   // 00 11 22 01 02 12
        logic signed [45:0]    ks [3];
        logic signed [47:0]    kvlo [6];
        logic signed [46:0]    kvhi [6];
        logic signed [27:0]    ksr [3];
        logic signed [27:0]    mt [6];
        logic signed [MW-1:0]  m [9];
        logic signed [PRW-1:0] mp [9];
        logic signed [CW-1:0]  o [3];
        logic                  sat;
    } pl_t;

    pl_t              st_reg  [NST];
    pl_t              st_next [NST];
    logic [NST-1:0]   vld_reg;
    logic             en;

    logic signed [15:0] body_lift_reg;
    logic [13:0]        max_turn_reg;

    // ---------------- configuration ----------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_lift_reg <= bpat_pkg::BODY_LIFT_RST;
            max_turn_reg  <= bpat_pkg::MAX_TURN_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.idx)
                bpat_pkg::REG_BODY_LIFT: body_lift_reg <= cfg.data[15:0];
                bpat_pkg::REG_MAX_TURN:  max_turn_reg  <= cfg.data[13:0];
                default:                 ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // single enable: the pipe moves as one unless the output item is held
    assign en          = !vld_reg[LAST] || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], in_ch.valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int g = 0; g < NST; g++)
                st_reg[g] <= st_next[g];
        end
    end

    // ---------------- stage 0: shift clamp, squares ----------------
    always_comb
    begin
        logic signed [15:0] mxc, myc, mzc;
        logic signed [29:0] pr [3];
        st_next[0] = st_reg[0];
        mxc = (in_ch.move_x > 16'sd480) ? 16'sd480 :
              (in_ch.move_x < -16'sd480) ? -16'sd480 : in_ch.move_x;
        myc = (in_ch.move_y > 16'sd480) ? 16'sd480 :
              (in_ch.move_y < -16'sd480) ? -16'sd480 : in_ch.move_y;
        mzc = (in_ch.move_z > 16'sd0) ? 16'sd0 :
              (in_ch.move_z < -16'sd720) ? -16'sd720 : in_ch.move_z;
        st_next[0].p[0] = PW'(in_ch.leg_x) + PW'(mxc);
        st_next[0].p[1] = PW'(in_ch.leg_y) + PW'(myc);
        st_next[0].p[2] = PW'(body_lift_reg) + PW'(mzc);
        st_next[0].r[0] = in_ch.rot_x;
        st_next[0].r[1] = in_ch.rot_y;
        st_next[0].r[2] = in_ch.rot_z;
        pr[0] = in_ch.rot_x * in_ch.rot_x;
        pr[1] = in_ch.rot_y * in_ch.rot_y;
        pr[2] = in_ch.rot_z * in_ch.rot_z;
        for (int i = 0; i < 3; i++)
            st_next[0].sq[i] = pr[i];
    end

    // ---------------- stages 1..LAST ----------------
    for (genvar g = 1; g < NST; g++)
    begin : g_stage
        if (g == ST_SUM)
        begin : g_sum
            always_comb
            begin
                st_next[g]      = st_reg[g-1];
                st_next[g].s    = {2'b0, st_reg[g-1].sq[0]} + {2'b0, st_reg[g-1].sq[1]}
                                + {2'b0, st_reg[g-1].sq[2]};
                st_next[g].zero = (st_next[g].s == 32'd0);
                st_next[g].srem = '0;
                st_next[g].lh   = '0;
            end
        end
        else if (g < ST_PREP)
        begin : g_sqrt
            // two root bits of floor(sqrt(s * 2^32)) per stage
            localparam int J0 = 2 * (g - ST_SQ);
            always_comb
            begin
                logic [63:0] nw;
                logic [35:0] rem, trial;
                logic [31:0] root;
                st_next[g] = st_reg[g-1];
                nw   = {st_reg[g-1].s, 32'b0};
                rem  = {2'b0, st_reg[g-1].srem};
                root = st_reg[g-1].lh;
                for (int u = 0; u < 2; u++)
                begin
                    rem   = {rem[33:0], nw[63-2*(J0+u) -: 2]};
                    trial = {2'b0, root, 2'b01};
                    if (rem >= trial)
                    begin
                        rem  = rem - trial;
                        root = {root[30:0], 1'b1};
                    end
                    else
                        root = {root[30:0], 1'b0};
                end
                st_next[g].srem = rem[33:0];
                st_next[g].lh   = root;
            end
        end
        else if (g == ST_PREP)
        begin : g_prep
            // angle clamp, quadrant fold, divider and CORDIC start values
            always_comb
            begin
                logic [32:0]        angs;
                logic [16:0]        angr;
                logic [13:0]        a;
                logic signed [14:0] as15;
                logic [14:0]        mag;
                st_next[g] = st_reg[g-1];
                angs = {1'b0, st_reg[g-1].lh} + 33'd32768;
                angr = st_reg[g-1].zero ? 17'd0 : angs[32:16];
                if (angr > {3'b0, max_turn_reg})
                    a = max_turn_reg;
                else
                    a = angr[13:0];
                st_next[g].flip = (a > 14'd5760);
                if (st_next[g].flip)
                    as15 = $signed({1'b0, a}) - 15'sd11520;
                else
                    as15 = $signed({1'b0, a});
                st_next[g].cz = {as15, 10'b0};
                st_next[g].cx = bpat_pkg::CORDIC_X0;
                st_next[g].cy = '0;
                for (int i = 0; i < 3; i++)
                begin
                    mag = st_reg[g-1].r[i][14] ? (~st_reg[g-1].r[i] + 15'd1)
                                               : st_reg[g-1].r[i];
                    st_next[g].drem[i] = {3'b0, mag, 34'b0} + {21'b0, st_reg[g-1].lh[31:1]};
                    st_next[g].dq[i]   = '0;
                    st_next[g].neg[i]  = st_reg[g-1].r[i][14];
                end
            end
        end
        else if (g < ST_F1)
        begin : g_div
            localparam int D = g - ST_DIV;
            localparam int B = DIV_N - 1 - D;
            always_comb
            begin
                logic [51:0]        cmp;
                logic signed [31:0] t;
                st_next[g] = st_reg[g-1];
                cmp = {20'b0, st_reg[g-1].lh} << B;
                for (int i = 0; i < 3; i++)
                begin
                    if (st_reg[g-1].drem[i] >= cmp)
                    begin
                        st_next[g].drem[i]  = st_reg[g-1].drem[i] - cmp;
                        st_next[g].dq[i][B] = 1'b1;
                    end
                end
                if (D < CORD_N)
                begin
                    if (st_reg[g-1].cz >= 0)
                    begin
                        t = st_reg[g-1].cx - (st_reg[g-1].cy >>> D);
                        st_next[g].cy = st_reg[g-1].cy + (st_reg[g-1].cx >>> D);
                        st_next[g].cz = st_reg[g-1].cz - bpat_pkg::atan_deg16(D);
                    end
                    else
                    begin
                        t = st_reg[g-1].cx + (st_reg[g-1].cy >>> D);
                        st_next[g].cy = st_reg[g-1].cy - (st_reg[g-1].cx >>> D);
                        st_next[g].cz = st_reg[g-1].cz + bpat_pkg::atan_deg16(D);
                    end
                    st_next[g].cx = t;
                end
            end
        end
        else if (g == ST_F1)
        begin : g_f1
            // cos/sin to Q24, signed axis
            always_comb
            begin
                logic signed [32:0] rx, ry;
                logic signed [25:0] cr, sr;
                logic signed [19:0] kq;
                st_next[g] = st_reg[g-1];
                rx = ($signed({st_reg[g-1].cx[31], st_reg[g-1].cx}) + 33'sd32) >>> 6;
                ry = ($signed({st_reg[g-1].cy[31], st_reg[g-1].cy}) + 33'sd32) >>> 6;
                cr = rx[25:0];
                sr = ry[25:0];
                st_next[g].c  = st_reg[g-1].flip ? -cr : cr;
                st_next[g].sn = st_reg[g-1].flip ? -sr : sr;
                st_next[g].v  = 27'sd16777216 - 27'(st_next[g].c);
                for (int i = 0; i < 3; i++)
                begin
                    kq = $signed({1'b0, st_reg[g-1].dq[i][18:0]});
                    st_next[g].k[i] = st_reg[g-1].neg[i] ? -kq : kq;
                end
                if (st_reg[g-1].zero)
                begin
                    st_next[g].k[0] = '0;
                    st_next[g].k[1] = '0;
                    st_next[g].k[2] = 20'sd262144;
                end
            end
        end
        else if (g == ST_F1 + 1)
        begin : g_f2
            always_comb
            begin
                st_next[g]       = st_reg[g-1];
                st_next[g].kk[0] = st_reg[g-1].k[0] * st_reg[g-1].k[0];
                st_next[g].kk[1] = st_reg[g-1].k[1] * st_reg[g-1].k[1];
                st_next[g].kk[2] = st_reg[g-1].k[2] * st_reg[g-1].k[2];
                st_next[g].kk[3] = st_reg[g-1].k[0] * st_reg[g-1].k[1];
                st_next[g].kk[4] = st_reg[g-1].k[0] * st_reg[g-1].k[2];
                st_next[g].kk[5] = st_reg[g-1].k[1] * st_reg[g-1].k[2];
                for (int i = 0; i < 3; i++)
                    st_next[g].ks[i] = st_reg[g-1].k[i] * st_reg[g-1].sn;
            end
        end
        else if (g == ST_F1 + 2)
        begin : g_f3
            // kk * v split into two narrow products; k * sin rounded
            always_comb
            begin
                logic signed [45:0] kr;
                st_next[g] = st_reg[g-1];
                for (int n = 0; n < 6; n++)
                begin
                    st_next[g].kvlo[n] = $signed({1'b0, st_reg[g-1].kk[n][19:0]})
                                       * st_reg[g-1].v;
                    st_next[g].kvhi[n] = $signed(st_reg[g-1].kk[n][39:20]) * st_reg[g-1].v;
                end
                for (int i = 0; i < 3; i++)
                begin
                    kr = (st_reg[g-1].ks[i] + 46'sd131072) >>> 18;
                    st_next[g].ksr[i] = kr[27:0];
                end
            end
        end
        else if (g == ST_F1 + 3)
        begin : g_f4
            always_comb
            begin
                logic signed [67:0] t;
                st_next[g] = st_reg[g-1];
                for (int n = 0; n < 6; n++)
                begin
                    t = (68'(st_reg[g-1].kvhi[n]) <<< 20) + 68'(st_reg[g-1].kvlo[n]);
                    t = (t + (68'sd1 <<< 35)) >>> 36;
                    st_next[g].mt[n] = t[27:0];
                end
            end
        end
        else if (g == ST_F1 + 4)
        begin : g_f5
            // Rodrigues matrix, row major
            always_comb
            begin
                logic signed [MW-1:0] cc;
                logic signed [MW-1:0] mt [6];
                logic signed [MW-1:0] kr [3];
                st_next[g] = st_reg[g-1];
                cc = MW'(st_reg[g-1].c);
                for (int n = 0; n < 6; n++)
                    mt[n] = MW'(st_reg[g-1].mt[n]);
                for (int i = 0; i < 3; i++)
                    kr[i] = MW'(st_reg[g-1].ksr[i]);
                st_next[g].m[0] = mt[0] + cc;
                st_next[g].m[1] = mt[3] - kr[2];
                st_next[g].m[2] = mt[4] + kr[1];
                st_next[g].m[3] = mt[3] + kr[2];
                st_next[g].m[4] = mt[1] + cc;
                st_next[g].m[5] = mt[5] - kr[0];
                st_next[g].m[6] = mt[4] - kr[1];
                st_next[g].m[7] = mt[5] + kr[0];
                st_next[g].m[8] = mt[2] + cc;
            end
        end
        else if (g == ST_F1 + 5)
        begin : g_f6
            always_comb
            begin
                st_next[g] = st_reg[g-1];
                for (int n = 0; n < 9; n++)
                    st_next[g].mp[n] = st_reg[g-1].m[n] * st_reg[g-1].p[n % 3];
            end
        end
        else
        begin : g_f7
            // row sums, round, saturate
            always_comb
            begin
                logic signed [AW-1:0] acc;
                logic                 sat;
                st_next[g] = st_reg[g-1];
                sat = 1'b0;
                for (int i = 0; i < 3; i++)
                begin
                    acc = AW'(st_reg[g-1].mp[3*i]) + AW'(st_reg[g-1].mp[3*i+1])
                        + AW'(st_reg[g-1].mp[3*i+2]);
                    acc = (acc + RND) >>> 24;
                    if (acc > OHI)
                    begin
                        st_next[g].o[i] = OHI[CW-1:0];
                        sat = 1'b1;
                    end
                    else if (acc < OLO)
                    begin
                        st_next[g].o[i] = OLO[CW-1:0];
                        sat = 1'b1;
                    end
                    else
                        st_next[g].o[i] = acc[CW-1:0];
                end
                st_next[g].sat = sat;
            end
        end
    end

    // ---------------- output ----------------
    assign out_ch.valid     = vld_reg[LAST];
    assign out_ch.out_x     = st_reg[LAST].o[0];
    assign out_ch.out_y     = st_reg[LAST].o[1];
    assign out_ch.out_z     = st_reg[LAST].o[2];
    assign out_ch.saturated = st_reg[LAST].sat;

endmodule
`default_nettype wire

// ----- tb/tb_body_pose_axis_angle_transform_core.sv -----
// Testbench for the body pose axis-angle transform core: predicted points checked item by item.
`timescale 1ns / 1ps
module tb_body_pose_axis_angle_transform_core;

    localparam int CW = bpat_pkg::COORD_WIDTH_DEF;
    localparam longint CYCLE_LIMIT = 400000;

    // index past the two registers, must be ignored
    localparam logic [bpat_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    bpat_in_if  #(.COORD_WIDTH(CW)) in_ch();
    bpat_out_if #(.COORD_WIDTH(CW)) out_ch();
    bpat_cfg_if                     cfg();

    body_pose_axis_angle_transform_core #(.COORD_WIDTH(CW)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // one expected result item
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 sat;
    } point_t;

    // atan(2^-i) in 2^-16 degree
    localparam longint ATAN_TBL [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
        58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    // predictor copy of the registers
    logic signed [15:0] lift_q;
    logic [13:0]        turn_lim_q;

    point_t pose_q[$];
    int     err_count;
    int     items_sent;
    int     points_seen;
    int     sat_seen;
    longint cycles;
    bit     quiet_in;     // no random idling on the sender
    bit     quiet_out;    // no random stalls on the receiver

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // floor shift right, valid for negative values too
    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd_shr(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [63:0] root64(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unit_axis(longint r, logic [63:0] lh);
        logic [63:0] mag;
        longint      q;
        mag = r < 0 ? -r : r;
        q = longint'(((mag << 34) + lh / 2) / lh);
        return r < 0 ? -q : q;
    endfunction

    // expected transformed point for one input item
    function automatic point_t pose_predict(logic signed [CW-1:0] lx, logic signed [CW-1:0] ly,
                                            logic signed [15:0] mx, logic signed [15:0] my,
                                            logic signed [15:0] mz, logic signed [14:0] rx,
                                            logic signed [14:0] ry, logic signed [14:0] rz);
        longint      p[3], r[3], k[3], m[3][3];
        longint      ang, cx, sy, zr, t, cs, sn, v, acc, o, hi, lo;
        logic [63:0] s2, lh;
        bit          flip;
        point_t      res;
        p[0] = longint'(lx) + clampv(mx, -480, 480);
        p[1] = longint'(ly) + clampv(my, -480, 480);
        p[2] = longint'(lift_q) + clampv(mz, -720, 0);
        r[0] = rx;
        r[1] = ry;
        r[2] = rz;
        s2 = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
        if (s2 == 0)
        begin
            k = '{0, 0, 1 << 18};
            ang = 0;
        end
        else
        begin
            lh = root64(s2 << 32);
            for (int i = 0; i < 3; i++)
                k[i] = unit_axis(r[i], lh);
            ang = longint'((lh + 32768) >> 16);
        end
        if (ang > longint'(turn_lim_q))
            ang = turn_lim_q;
        // CORDIC sin/cos, folded past 90 degrees
        flip = 0;
        if (ang > 5760)
        begin
            ang = ang - 11520;
            flip = 1;
        end
        cx = 652032874;
        sy = 0;
        zr = ang * 1024;
        for (int i = 0; i < 16; i++)
        begin
            if (zr >= 0)
            begin
                t = cx - fshr(sy, i);
                sy = sy + fshr(cx, i);
                zr = zr - ATAN_TBL[i];
            end
            else
            begin
                t = cx + fshr(sy, i);
                sy = sy - fshr(cx, i);
                zr = zr + ATAN_TBL[i];
            end
            cx = t;
        end
        cs = rnd_shr(cx, 6);
        sn = rnd_shr(sy, 6);
        if (flip)
        begin
            cs = -cs;
            sn = -sn;
        end
        v = (longint'(1) << 24) - cs;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = rnd_shr(k[i] * k[j] * v, 36);
        for (int i = 0; i < 3; i++)
            m[i][i] += cs;
        m[0][1] -= rnd_shr(k[2] * sn, 18);
        m[1][0] += rnd_shr(k[2] * sn, 18);
        m[0][2] += rnd_shr(k[1] * sn, 18);
        m[2][0] -= rnd_shr(k[1] * sn, 18);
        m[1][2] -= rnd_shr(k[0] * sn, 18);
        m[2][1] += rnd_shr(k[0] * sn, 18);
        hi = (longint'(1) << (CW - 1)) - 1;
        lo = -hi - 1;
        res.sat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            acc = m[i][0] * p[0] + m[i][1] * p[1] + m[i][2] * p[2];
            o = rnd_shr(acc, 24);
            if (o > hi || o < lo)
                res.sat = 1'b1;
            o = clampv(o, lo, hi);
            if (i == 0) res.x = o[CW-1:0];
            else if (i == 1) res.y = o[CW-1:0];
            else res.z = o[CW-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        err_count++;
        $display("mismatch %s at result %0d: got %0d want %0d", what, points_seen, got, want);
    endtask

    // one item through in_ch; waits for the handshake
    task automatic send_point(logic signed [CW-1:0] lx, logic signed [CW-1:0] ly,
                              logic signed [15:0] mx, logic signed [15:0] my,
                              logic signed [15:0] mz, logic signed [14:0] rx,
                              logic signed [14:0] ry, logic signed [14:0] rz);
        while (!quiet_in && $urandom_range(99) < 6)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.leg_x  <= lx;
        in_ch.leg_y  <= ly;
        in_ch.move_x <= mx;
        in_ch.move_y <= my;
        in_ch.move_z <= mz;
        in_ch.rot_x  <= rx;
        in_ch.rot_y  <= ry;
        in_ch.rot_z  <= rz;
        pose_q.push_back(pose_predict(lx, ly, mx, my, mz, rx, ry, rz));
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // park the sender and let the pipe empty out
    task automatic drain_pipe();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pose_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // register write, only with the pipe empty; also updates the predictor
    task automatic write_reg(logic [bpat_pkg::CFG_IDX_W-1:0] idx,
                             logic [bpat_pkg::CFG_DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.idx   <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        if (idx == bpat_pkg::REG_BODY_LIFT)
            lift_q = val;
        else if (idx == bpat_pkg::REG_MAX_TURN)
            turn_lim_q = val[13:0];
        @(posedge clk);
    endtask

    function automatic logic signed [14:0] rnd_rot();
        case ($urandom_range(5))
            0: return 15'(int'($urandom_range(0, 32767)));      // full 15-bit field
            1: return 15'(int'($urandom_range(0, 40)) - 20);     // tiny vectors
            2: return 0;
            default: return 15'(int'($urandom_range(0, 23040)) - 11520);
        endcase
    endfunction

    function automatic logic signed [15:0] rnd_move();
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 1200)) - 800);
    endfunction

    function automatic logic signed [CW-1:0] rnd_leg();
        if ($urandom_range(3) == 0)
            return CW'($urandom);
        return CW'(int'($urandom_range(0, 8000)) - 4000);
    endfunction

    task automatic send_random(int n);
        for (int i = 0; i < n; i++)
            send_point(rnd_leg(), rnd_leg(), rnd_move(), rnd_move(), rnd_move(),
                       rnd_rot(), rnd_rot(), rnd_rot());
    endtask

    // extremes of every field and the named special cases
    task automatic test_directed();
        send_point(0, 0, 0, 0, 0, 0, 0, 0);                                // zero vector: +z axis
        send_point(1600, -1600, 0, 0, 0, 0, 0, 0);
        send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0);
        send_point(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0);
        send_point(1000, 500, 480, -480, -720, 0, 0, 960);                 // at the turn limit
        send_point(1000, 500, 481, -481, 1, 0, 0, 5000);                   // clamped angle
        send_point(1000, 500, 0, 0, -721, 11520, 0, 0);
        send_point(-1000, 700, 0, 0, 0, 0, -11520, 0);
        send_point(-1000, 700, 0, 0, 0, 0, 0, -11520);
        send_point(300, 300, 0, 0, 0, 15'sh3fff, 15'sh3fff, 15'sh3fff);    // out-of-range rot
        send_point(300, 300, 0, 0, 0, 15'sh4000, 15'sh4000, 15'sh4000);
        send_point(32000, -32000, 480, -480, 0, 100, 100, 100);            // saturates
        send_point(-32768, 32767, -480, 480, -720, -1, 1, -1);
    endtask

    // angle range: zero, just past 90 degrees, 180, full register width, and 3000
    task automatic test_turn_limits();
        logic [bpat_pkg::CFG_DATA_W-1:0] lims [5] = '{0, 5761, 11520, 16383, 3000};
        foreach (lims[n])
        begin
            drain_pipe();
            write_reg(bpat_pkg::REG_MAX_TURN, lims[n]);
            send_point(2000, -1500, 0, 0, 0, 0, 0, 16383);
            send_point(2000, -1500, 100, -50, -300, 5800, 0, 0);
            send_point(-2000, 1500, 0, 0, 0, 6000, -6000, 6000);
            send_point(-2000, 1500, 0, 0, 0, 0, 11520, 0);
            send_random(60);
        end
    endtask

    // body lift extremes, unused register index ignored
    task automatic test_body_lift();
        logic [bpat_pkg::CFG_DATA_W-1:0] lifts [4] = '{16'h7fff, 16'h8000, 16'hfc00, 16'h0500};
        foreach (lifts[n])
        begin
            drain_pipe();
            write_reg(bpat_pkg::REG_BODY_LIFT, lifts[n]);
            write_reg(REG_UNUSED, 16'hffff);
            send_point(0, 0, 0, 0, 0, 0, 0, 0);
            send_point(0, 0, 0, 0, -720, 3000, 3000, 0);
            send_random(80);
        end
    endtask

    // bulk traffic with random idling and stalls, then a stretch with none, then random again
    task automatic test_random_bulk();
        drain_pipe();
        write_reg(bpat_pkg::REG_MAX_TURN, 11520);
        send_random(700);
        drain_pipe();
        write_reg(bpat_pkg::REG_BODY_LIFT, 16'hff00);
        write_reg(bpat_pkg::REG_MAX_TURN, 960);
        quiet_in = 1;
        quiet_out = 1;
        send_random(400);
        quiet_in = 0;
        quiet_out = 0;
        send_random(190);
    endtask

    // receiver: random stalls, compare against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pose_q.size() == 0)
                report_mismatch("unexpected item", 1, 0);
            else
            begin
                point_t want;
                want = pose_q.pop_front();
                if (out_ch.out_x !== want.x) report_mismatch("out_x", out_ch.out_x, want.x);
                if (out_ch.out_y !== want.y) report_mismatch("out_y", out_ch.out_y, want.y);
                if (out_ch.out_z !== want.z) report_mismatch("out_z", out_ch.out_z, want.z);
                if (out_ch.saturated !== want.sat)
                    report_mismatch("saturated", out_ch.saturated, want.sat);
                if (want.sat) sat_seen++;
            end
            points_seen++;
        end
        out_ch.ready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 6);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles, pose_q.size());
            $display("[body_pose_axis_angle_transform_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        clk         = 1'b0;
        err_count   = 0;
        items_sent  = 0;
        points_seen = 0;
        sat_seen    = 0;
        cycles      = 0;
        quiet_in    = 0;
        quiet_out   = 0;
        lift_q      = bpat_pkg::BODY_LIFT_RST;
        turn_lim_q  = bpat_pkg::MAX_TURN_RST;
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.leg_x  = '0;
        in_ch.leg_y  = '0;
        in_ch.move_x = '0;
        in_ch.move_y = '0;
        in_ch.move_z = '0;
        in_ch.rot_x  = '0;
        in_ch.rot_y  = '0;
        in_ch.rot_z  = '0;
        out_ch.ready = 1'b0;
        cfg.valid    = 1'b0;
        cfg.idx      = '0;
        cfg.data     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_turn_limits();
        test_body_lift();
        test_random_bulk();

        drain_pipe();
        $display("sent %0d points, checked %0d results (%0d saturated)",
                 items_sent, points_seen, sat_seen);
        $display("covered turn limits 0..16383, body lift extremes, stalls on both sides");
        if (err_count == 0)
            $display("[body_pose_axis_angle_transform_core] OK");
        else
            $display("[body_pose_axis_angle_transform_core] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
design/bpat_pkg.sv
design/bpat_if.sv
design/body_pose_axis_angle_transform_core.sv
tb/tb_body_pose_axis_angle_transform_core.sv
